FILE: rtl/source_admission_flood_ban_unit_defines.svh
// Assertion macros for the admission table RTL
`ifndef SOURCE_ADMISSION_FLOOD_BAN_UNIT_DEFINES_SVH
`define SOURCE_ADMISSION_FLOOD_BAN_UNIT_DEFINES_SVH

// same-cycle implication
`define SAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define SAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/sab_pkg.sv
// Types, codes and entry record for the admission table
`default_nettype none
package sab_pkg;

  typedef enum logic [1:0] {
    ACT_CHECK      = 2'd0,
    ACT_CONNECT    = 2'd1,
    ACT_DISCONNECT = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OC_ADMITTED   = 4'd0,
    OC_ZERO_LIMIT = 4'd1,
    OC_RAPID_BAN  = 4'd2,
    OC_BANNED     = 4'd3,
    OC_FLOOD_BAN  = 4'd4,
    OC_OVER_LIMIT = 4'd5,
    OC_NEW        = 4'd6,
    OC_COUNTED    = 4'd7,
    OC_FULL       = 4'd8,
    OC_REMOVED    = 4'd9,
    OC_ABSENT     = 4'd10
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_EMIT
  } state_e;

  localparam logic [7:0] REG_MAX_CONN  = 8'd0;
  localparam logic [7:0] REG_RECONNECT = 8'd1;
  localparam logic [7:0] REG_BAN_DUR   = 8'd2;
  localparam logic [7:0] REG_FLOOD_WIN = 8'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // one table entry as it travels around the ring
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] count;
    logic [15:0] tries;
    logic        banned;
    logic [31:0] last_time;
    logic [31:0] prior_time;
    logic [31:0] ban_time;
    logic [31:0] last_over_time;
  } entry_t;

  typedef struct packed {
    logic [15:0] max_conn;
    logic [31:0] reconnect;
    logic [31:0] ban_dur;
    logic [31:0] flood_win;
  } cfg_t;

  // what the head logic reports for the entry passing by
  typedef struct packed {
    logic        hit;
    logic        free;
    logic        take;
    logic        admitted;
    outcome_e    outcome;
    logic [15:0] count;
  } head_res_t;

  // magnitude of a wrapped signed 32-bit difference
  function automatic logic [31:0] time_gap(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31] ? (32'd0 - d) : d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sab_cell.sv
// One table cell: holds an entry and passes it on while the ring turns
`default_nettype none
module sab_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire sab_pkg::entry_t entry_i,
  output sab_pkg::entry_t      entry_o
);
  import sab_pkg::*;

  logic   valid_q;
  entry_t data_q;

  // valid bit is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end
endmodule
`default_nettype wire

FILE: rtl/sab_head.sv
// Head of the ring: applies one item's action to the entry passing by
`default_nettype none
module sab_head (
  input  wire sab_pkg::entry_t  entry_i,
  input  wire sab_pkg::action_e action_i,
  input  wire logic [31:0]      addr_i,
  input  wire logic [31:0]      now_i,
  input  wire sab_pkg::cfg_t    cfg_i,
  input  wire logic             fill_i,
  input  wire logic             filled_i,
  output sab_pkg::entry_t       entry_o,
  output sab_pkg::head_res_t    res_o
);
  import sab_pkg::*;

  logic match;
  logic rapid, unban, still_banned, flood, over;
  logic [15:0] dec_count;

  assign match = entry_i.valid && (entry_i.addr == addr_i);

  // check timing tests, all against the old entry
  assign rapid        = time_gap(now_i, entry_i.last_time) < cfg_i.reconnect;
  assign unban        = entry_i.banned && (time_gap(now_i, entry_i.ban_time) > cfg_i.ban_dur);
  assign still_banned = entry_i.banned && !unban;
  assign flood        = (entry_i.tries != 16'd0) &&
                        (time_gap(now_i, entry_i.last_over_time) < cfg_i.flood_win);
  assign over         = entry_i.count >= cfg_i.max_conn;
  assign dec_count    = (entry_i.count != 16'd0) ? entry_i.count - 16'd1 : 16'd0;

  always_comb begin
    entry_o        = entry_i;
    res_o.hit      = 1'b0;
    res_o.free     = !entry_i.valid;
    res_o.take     = 1'b0;
    res_o.admitted = 1'b0;
    res_o.outcome  = OC_ABSENT;
    res_o.count    = entry_i.count;
    if (fill_i) begin
      // fill pass: first free entry takes the new source
      if (!entry_i.valid && !filled_i) begin
        res_o.take           = 1'b1;
        entry_o.valid        = 1'b1;
        entry_o.addr         = addr_i;
        entry_o.count        = 16'd1;
        entry_o.tries        = 16'd0;
        entry_o.banned       = 1'b0;
        entry_o.last_time    = now_i;
        entry_o.prior_time   = 32'd0;
        entry_o.ban_time     = 32'd0;
        entry_o.last_over_time = 32'd0;
      end
    end else if (match) begin
      unique case (action_i)
        ACT_CHECK: begin
          res_o.hit          = 1'b1;
          entry_o.prior_time = entry_i.last_time;
          entry_o.last_time  = now_i;
          if (rapid) begin
            entry_o.banned   = 1'b1;
            entry_o.ban_time = now_i;
            res_o.outcome    = OC_RAPID_BAN;
          end else begin
            if (unban) begin
              entry_o.banned   = 1'b0;
              entry_o.ban_time = 32'd0;
            end
            if (still_banned) begin
              res_o.outcome = OC_BANNED;
            end else if (flood) begin
              entry_o.banned   = 1'b1;
              entry_o.ban_time = now_i;
              res_o.outcome    = OC_FLOOD_BAN;
            end else if (over) begin
              if (entry_i.tries != COUNT_MAX) begin
                entry_o.tries = entry_i.tries + 16'd1;
              end
              entry_o.last_over_time = now_i;
              res_o.outcome          = OC_OVER_LIMIT;
            end else begin
              res_o.admitted = 1'b1;
              res_o.outcome  = OC_ADMITTED;
            end
          end
        end
        ACT_CONNECT: begin
          res_o.hit     = 1'b1;
          res_o.outcome = OC_COUNTED;
          if (entry_i.count != COUNT_MAX) begin
            entry_o.count = entry_i.count + 16'd1;
          end
          res_o.count = entry_o.count;
        end
        ACT_DISCONNECT: begin
          res_o.hit     = 1'b1;
          res_o.outcome = OC_REMOVED;
          entry_o.count = dec_count;
          res_o.count   = dec_count;
          if (dec_count == 16'd0 && !entry_i.banned) begin
            entry_o.valid = 1'b0;
          end
        end
        default: begin
          // unused code leaves the entry alone
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/source_admission_flood_ban_unit.sv
// Top level: per-source admission table built as a rotating ring of cells
`default_nettype none
// Each item is taken in while idle, then scanned while the whole table rotates
// once past the head logic, then, when a connect from an unknown source finds
// a free entry, passed through a second full rotation that fills that entry,
// and finally moved into the output register to present the result. One item is in
// work at a time; the finished result sits in an output register until taken.
// Configuration registers may be written whenever no item is in work.
module source_admission_flood_ban_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             admitted_o,
  output logic [3:0]       outcome_o,
  output logic [15:0]      connection_count_o,
  output logic             entry_found_o
);
  import sab_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  state_e   state_q, state_d;
  cfg_t     cfg_q;
  action_e  act_q;
  logic [31:0] addr_q, now_q;
  logic [IdxW-1:0] idx_q;
  logic     hit_q, free_q, filled_q;
  logic     res_adm_q;
  outcome_e res_oc_q;
  logic [15:0] res_cnt_q;
  logic     res_found_q;
  logic     out_valid_q, out_adm_q, out_found_q;
  outcome_e out_oc_q;
  logic [15:0] out_cnt_q;

  logic      in_acc, shift, pass_end, emit_load, go_fill;
  entry_t    cell_q [TABLE_ENTRIES];
  entry_t    head_out;
  head_res_t hres;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_conn  <= 16'd3;
      cfg_q.reconnect <= 32'd500;
      cfg_q.ban_dur   <= 32'd600000;
      cfg_q.flood_win <= 32'd60000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_CONN:  cfg_q.max_conn  <= cfg_data_i[15:0];
        REG_RECONNECT: cfg_q.reconnect <= cfg_data_i;
        REG_BAN_DUR:   cfg_q.ban_dur   <= cfg_data_i;
        REG_FLOOD_WIN: cfg_q.flood_win <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ring of cells, cell 0 feeds the head, head feeds the last cell
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t nxt;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nxt = head_out;
    end else begin : g_mid
      assign nxt = cell_q[i+1];
    end
    sab_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nxt),
      .entry_o (cell_q[i])
    );
  end

  sab_head u_head (
    .entry_i  (cell_q[0]),
    .action_i (act_q),
    .addr_i   (addr_q),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .fill_i   (state_q == ST_FILL),
    .filled_i (filled_q),
    .entry_o  (head_out),
    .res_o    (hres)
  );

  assign in_acc    = in_valid_i && !in_stall_o;
  assign pass_end  = (idx_q == LastIdx);
  assign go_fill   = (act_q == ACT_CONNECT) && !(hit_q || hres.hit) && (free_q || hres.free);
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (pass_end) state_d = go_fill ? ST_FILL : ST_EMIT;
      ST_FILL: if (pass_end) state_d = ST_EMIT;
      ST_EMIT: if (emit_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    shift      = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SCAN: shift = 1'b1;
      ST_FILL: shift = 1'b1;
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      filled_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) begin
        idx_q <= pass_end ? '0 : idx_q + IdxW'(1);
      end
      if (in_acc) begin
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
        filled_q <= 1'b0;
      end else begin
        if (state_q == ST_SCAN) begin
          hit_q  <= hit_q | hres.hit;
          free_q <= free_q | hres.free;
        end
        if (state_q == ST_FILL && hres.take) begin
          filled_q <= 1'b1;
        end
      end
    end
  end

  // item and result being built
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q       <= action_e'(action_i);
      addr_q      <= source_address_i;
      now_q       <= now_ms_i;
      res_adm_q   <= 1'b0;
      res_cnt_q   <= 16'd0;
      res_found_q <= 1'b0;
      unique case (action_e'(action_i))
        ACT_CHECK: begin
          res_adm_q <= (cfg_q.max_conn != 16'd0);
          res_oc_q  <= (cfg_q.max_conn != 16'd0) ? OC_ADMITTED : OC_ZERO_LIMIT;
        end
        ACT_CONNECT: res_oc_q <= OC_FULL;
        default:     res_oc_q <= OC_ABSENT;
      endcase
    end else if (state_q == ST_SCAN) begin
      if (hres.hit) begin
        res_adm_q   <= hres.admitted;
        res_oc_q    <= hres.outcome;
        res_cnt_q   <= hres.count;
        res_found_q <= 1'b1;
      end else if (pass_end && go_fill) begin
        res_oc_q  <= OC_NEW;
        res_cnt_q <= 16'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_adm_q   <= res_adm_q;
      out_oc_q    <= res_oc_q;
      out_cnt_q   <= res_cnt_q;
      out_found_q <= res_found_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign admitted_o         = out_adm_q;
  assign outcome_o          = out_oc_q;
  assign connection_count_o = out_cnt_q;
  assign entry_found_o      = out_found_q;

`include "source_admission_flood_ban_unit_defines.svh"

  `SAB_ASSERT_NEXT(a_accept_scans, clk_i, rst_ni, in_acc, state_q == ST_SCAN)
  `SAB_ASSERT_NOW(a_fill_has_free, clk_i, rst_ni, state_q == ST_FILL, free_q && !hit_q)
  `SAB_ASSERT_NOW(a_idx_only_busy, clk_i, rst_ni, idx_q != '0,
                  state_q == ST_SCAN || state_q == ST_FILL)
  `SAB_ASSERT_NEXT(a_fill_done, clk_i, rst_ni, state_q == ST_FILL && pass_end,
                   filled_q)
endmodule
`default_nettype wire

FILE: sim/tb_source_admission_flood_ban_unit.sv
// Testbench for the source admission table with flood banning
`timescale 1ns / 1ps
`default_nettype none

module tb_source_admission_flood_ban_unit;
  import sab_pkg::*;

  localparam int NUM_ENTRIES = 64;
  localparam int IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic        admitted;
    outcome_e    outcome;
    logic [15:0] count;
    logic        found;
  } verdict_t;

  // admission table model and queue of pending verdicts
  class admission_scoreboard;
    logic [15:0] max_conn;
    logic [31:0] reconnect_ms;
    logic [31:0] ban_ms;
    logic [31:0] flood_ms;
    logic        valid    [NUM_ENTRIES];
    logic [31:0] addr     [NUM_ENTRIES];
    logic [15:0] count    [NUM_ENTRIES];
    logic [15:0] tries    [NUM_ENTRIES];
    logic        banned   [NUM_ENTRIES];
    logic [31:0] last_t   [NUM_ENTRIES];
    logic [31:0] prior_t  [NUM_ENTRIES];
    logic [31:0] ban_t    [NUM_ENTRIES];
    logic [31:0] over_t   [NUM_ENTRIES];
    verdict_t    pending[$];
    int          errors;

    function new();
      max_conn = 16'd3;
      reconnect_ms = 32'd500;
      ban_ms = 32'd600000;
      flood_ms = 32'd60000;
      errors = 0;
      foreach (valid[i]) valid[i] = 1'b0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_CONN:  max_conn = val[15:0];
        REG_RECONNECT: reconnect_ms = val;
        REG_BAN_DUR:   ban_ms = val;
        REG_FLOOD_WIN: flood_ms = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] gap(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31] ? -d : d;
    endfunction

    // check on a known entry; tests in priority order
    function void check_known(int i, logic [31:0] now, ref verdict_t v);
      prior_t[i] = last_t[i];
      last_t[i] = now;
      if (gap(now, prior_t[i]) < reconnect_ms) begin
        banned[i] = 1'b1;
        ban_t[i] = now;
        v.outcome = OC_RAPID_BAN;
        return;
      end
      if (banned[i] && gap(now, ban_t[i]) > ban_ms) begin
        banned[i] = 1'b0;
        ban_t[i] = '0;
      end
      if (banned[i]) begin
        v.outcome = OC_BANNED;
      end else if (tries[i] != 0 && gap(now, over_t[i]) < flood_ms) begin
        banned[i] = 1'b1;
        ban_t[i] = now;
        v.outcome = OC_FLOOD_BAN;
      end else if (count[i] >= max_conn) begin
        if (tries[i] != COUNT_MAX) tries[i]++;
        over_t[i] = now;
        v.outcome = OC_OVER_LIMIT;
      end else begin
        v.admitted = 1'b1;
        v.outcome = OC_ADMITTED;
      end
    endfunction

    function void note_item(action_e act, logic [31:0] src, logic [31:0] now);
      verdict_t v;
      int hit;
      int slot;
      v = '{admitted: 1'b0, outcome: OC_ABSENT, count: 16'd0, found: 1'b0};
      hit = -1;
      slot = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (hit < 0 && valid[i] && addr[i] == src) hit = i;
        if (slot < 0 && !valid[i]) slot = i;
      end
      case (act)
        ACT_CHECK: begin
          if (hit < 0) begin
            v.admitted = (max_conn != 0);
            v.outcome = v.admitted ? OC_ADMITTED : OC_ZERO_LIMIT;
          end else begin
            v.found = 1'b1;
            check_known(hit, now, v);
            v.count = count[hit];
          end
        end
        ACT_CONNECT: begin
          if (hit >= 0) begin
            v.found = 1'b1;
            if (count[hit] != COUNT_MAX) count[hit]++;
            v.count = count[hit];
            v.outcome = OC_COUNTED;
          end else if (slot < 0) begin
            v.outcome = OC_FULL;
          end else begin
            valid[slot] = 1'b1;
            addr[slot] = src;
            count[slot] = 16'd1;
            tries[slot] = '0;
            banned[slot] = 1'b0;
            last_t[slot] = now;
            prior_t[slot] = '0;
            ban_t[slot] = '0;
            over_t[slot] = '0;
            v.count = 16'd1;
            v.outcome = OC_NEW;
          end
        end
        ACT_DISCONNECT: begin
          if (hit >= 0) begin
            v.found = 1'b1;
            if (count[hit] != 0) count[hit]--;
            v.count = count[hit];
            if (count[hit] == 0 && !banned[hit]) valid[hit] = 1'b0;
            v.outcome = OC_REMOVED;
          end
        end
        default: ;
      endcase
      pending.push_back(v);
    endfunction

    function void check_result(logic adm, logic [3:0] oc, logic [15:0] cnt, logic fnd);
      verdict_t v;
      if (pending.size() == 0) begin
        $error("unexpected result outcome=%0d", oc);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (adm !== v.admitted) begin
        $error("admitted: expected %0d, got %0d", v.admitted, adm);
        errors++;
      end
      if (oc !== v.outcome) begin
        $error("outcome: expected %0d, got %0d", v.outcome, oc);
        errors++;
      end
      if (cnt !== v.count) begin
        $error("connection_count: expected %0d, got %0d", v.count, cnt);
        errors++;
      end
      if (fnd !== v.found) begin
        $error("entry_found: expected %0d, got %0d", v.found, fnd);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [31:0] source_address_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        admitted_o;
  logic [3:0]  outcome_o;
  logic [15:0] connection_count_o;
  logic        entry_found_o;

  admission_scoreboard board = new();
  int  idle_cycles = 0;
  bit  stim_done = 0;
  bit  hold_sink = 0;
  logic [31:0] clock_ms = 32'd1000;
  logic [31:0] src_pool[16];

  source_admission_flood_ban_unit #(.TABLE_ENTRIES(NUM_ENTRIES)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register write while idle, mirrored into the model
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // drive one item after a random gap and wait for acceptance;
  // valid stays high after acceptance until the next gap or drain
  task automatic send_item(action_e act, logic [31:0] src, logic [31:0] now);
    int gap_cycles;
    gap_cycles = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap_cycles = 0;
    if (gap_cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    source_address_i <= src;
    now_ms_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(act, src, now);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // random item mostly on a small pool of sources, time mostly advancing but sometimes jumping to a random value
  task automatic random_item();
    action_e act;
    logic [31:0] src;
    int r;
    r = $urandom_range(0, 99);
    act = (r < 45) ? ACT_CHECK : (r < 75) ? ACT_CONNECT : (r < 98) ? ACT_DISCONNECT : ACT_NONE;
    src = ($urandom_range(0, 9) == 0) ? $urandom() : src_pool[$urandom_range(0, 15)];
    case ($urandom_range(0, 5))
      0: clock_ms = clock_ms + $urandom_range(0, 400);
      1: clock_ms = clock_ms + $urandom_range(0, 70000);
      2: clock_ms = clock_ms + $urandom_range(0, 700000);
      3: clock_ms = $urandom();
      default: clock_ms = clock_ms + $urandom_range(0, 3000);
    endcase
    send_item(act, src, clock_ms);
  endtask

  // result side: random stalls, plus a long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      board.check_result(admitted_o, outcome_o, connection_count_o, entry_found_o);
  end

  // watchdog on acceptance activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // long hold on the result side while items keep coming
  task automatic hold_results();
    hold_sink = 1;
    repeat (400) @(posedge clk_i);
    hold_sink = 0;
  endtask

  initial begin
    foreach (src_pool[i]) src_pool[i] = $urandom();
    src_pool[0] = 32'h0;
    src_pool[1] = 32'hFFFF_FFFF;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings
    send_item(ACT_CHECK, 32'h0, 32'd0);
    send_item(ACT_CONNECT, 32'h0, 32'd0);
    send_item(ACT_CHECK, 32'h0, 32'd100);
    send_item(ACT_CHECK, 32'h0, 32'd200);
    send_item(ACT_CHECK, 32'h0, 32'd900000);
    send_item(ACT_CONNECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_CONNECT, 32'hFFFF_FFFF, 32'd5);
    send_item(ACT_CONNECT, 32'hFFFF_FFFF, 32'd6);
    send_item(ACT_CHECK, 32'hFFFF_FFFF, 32'd1000);
    send_item(ACT_CHECK, 32'hFFFF_FFFF, 32'd2000);
    send_item(ACT_CHECK, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_DISCONNECT, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_DISCONNECT, 32'h1234_5678, 32'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF, 32'hAAAA_5555);
    // fill the table, then overflow it
    for (int i = 0; i < NUM_ENTRIES + 1; i++)
      send_item(ACT_CONNECT, 32'h0A00_0000 + i, 32'd10);
    for (int i = 0; i < NUM_ENTRIES; i++)
      send_item(ACT_DISCONNECT, 32'h0A00_0000 + i, 32'd10);
    drain();

    // zero limit and extremes of the time registers
    write_reg(REG_MAX_CONN, 32'd0);
    write_reg(REG_RECONNECT, 32'd0);
    write_reg(REG_BAN_DUR, 32'hFFFF_FFFF);
    write_reg(REG_FLOOD_WIN, 32'hFFFF_FFFF);
    write_reg(8'd7, 32'd9);
    send_item(ACT_CHECK, 32'h5555_AAAA, 32'd0);
    for (int i = 0; i < 300; i++) random_item();
    drain();

    // saturation settings: maximum connection limit and reconnect window, zero ban and flood windows
    write_reg(REG_MAX_CONN, 32'd65535);
    write_reg(REG_RECONNECT, 32'hFFFF_FFFF);
    write_reg(REG_BAN_DUR, 32'd0);
    write_reg(REG_FLOOD_WIN, 32'd0);
    fork
      hold_results();
      for (int i = 0; i < 300; i++) random_item();
    join
    drain();

    // moderate settings that exercise flood bans
    write_reg(REG_MAX_CONN, 32'd1);
    write_reg(REG_RECONNECT, 32'd200);
    write_reg(REG_BAN_DUR, 32'd100000);
    write_reg(REG_FLOOD_WIN, 32'd60000);
    for (int i = 0; i < 450; i++) random_item();
    drain();

    write_reg(REG_MAX_CONN, 32'd3);
    write_reg(REG_RECONNECT, 32'd500);
    write_reg(REG_BAN_DUR, 32'd600000);
    write_reg(REG_FLOOD_WIN, 32'd60000);
    for (int i = 0; i < 450; i++) random_item();
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
